[rtl/tlbpt_pkg.sv]
package tlbpt_pkg;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned FRAME_W = 8;
    localparam int unsigned FREE_W  = 9;
    localparam int unsigned CNT_W   = 32;

    localparam int unsigned TLB_ENTRIES_DEF = 16;
    localparam int unsigned PT_ENTRIES_DEF  = 256;
    localparam int unsigned PAGE_BYTES_DEF  = 256;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } pte_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tlb_res_t;

    typedef struct packed {
        logic               en;
        logic [FRAME_W-1:0] frame;
    } tlb_fill_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

[rtl/tlbpt_if.sv]
interface tlbpt_req_if import tlbpt_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] logical_address;

    modport source (output valid, output logical_address, input ready);
    modport sink   (input valid, input logical_address, output ready);
endinterface

interface tlbpt_rsp_if import tlbpt_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  physical_address;
    logic [FRAME_W-1:0] frame_number;
    logic               tlb_hit;
    logic               page_fault;
    logic [CNT_W-1:0]   access_count;
    logic [CNT_W-1:0]   fault_count;
    logic [CNT_W-1:0]   hit_count;

    modport source (output valid, output physical_address, output frame_number,
                    output tlb_hit, output page_fault, output access_count,
                    output fault_count, output hit_count, input ready);
    modport sink   (input valid, input physical_address, input frame_number,
                    input tlb_hit, input page_fault, input access_count,
                    input fault_count, input hit_count, output ready);
endinterface

[rtl/tlbpt_ram.sv]
module tlbpt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tlbpt_tlb.sv]
module tlbpt_tlb import tlbpt_pkg::*; #(
    parameter int unsigned TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int unsigned PAGE_W      = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PAGE_W-1:0] page,
    output tlb_res_t          res,
    input  tlb_fill_t         fill
);

    localparam int unsigned IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TLB_ENTRIES - 1);

    logic               valid_reg [TLB_ENTRIES];
    logic [PAGE_W-1:0]  page_reg  [TLB_ENTRIES];
    logic [FRAME_W-1:0] frame_reg [TLB_ENTRIES];
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   ptr_next;
    logic [IDX_W-1:0]   sel;
    logic               hit;

    // The lowest matching entry wins.
    always_comb
    begin
        hit = 1'b0;
        sel = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && page_reg[i] == page)
            begin
                hit = 1'b1;
                sel = IDX_W'(i);
            end
        end
    end

    assign res.hit   = hit;
    assign res.frame = frame_reg[sel];
    assign ptr_next  = (ptr_reg == LAST) ? '0 : ptr_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (fill.en)
        begin
            ptr_reg            <= ptr_next;
            valid_reg[ptr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill.en)
        begin
            page_reg[ptr_reg]  <= page;
            frame_reg[ptr_reg] <= fill.frame;
        end
    end

    a_fill_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        fill.en |-> !res.hit)
        else $error("TLB fill issued while the page hits");

endmodule

[rtl/tlb_page_table_translator.sv]
// Channel | Direction | Beat contents
// req     | in        | logical_address
// rsp     | out       | physical_address, frame_number, tlb_hit, page_fault, counts
//
// Each beat does the page table memory read, then the update in the lookup state.
// A new request beat is taken only while no beat is in flight.
// After reset a clearing pass writes every page table entry.
// The response sits in an output register; the next request is taken while it waits.
// A beat waits in the update cycle while the output register is full and not taken.
module tlb_page_table_translator import tlbpt_pkg::*; #(
    parameter int unsigned TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int unsigned PT_ENTRIES  = PT_ENTRIES_DEF,
    parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tlbpt_req_if.sink   req,
    tlbpt_rsp_if.source rsp
);

    localparam int unsigned OFS_W = $clog2(PAGE_BYTES);
    localparam int unsigned PT_W  = $clog2(PT_ENTRIES);
    localparam logic [PT_W-1:0] PT_LAST = PT_W'(PT_ENTRIES - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [PT_W-1:0]    clr_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [FREE_W-1:0]  free_reg;
    logic [CNT_W-1:0]   acc_reg;
    logic [CNT_W-1:0]   flt_reg;
    logic [CNT_W-1:0]   hit_reg;
    logic [CNT_W-1:0]   acc_next;
    logic [CNT_W-1:0]   flt_next;
    logic [CNT_W-1:0]   hit_next;

    logic               ov_reg;
    logic [ADDR_W-1:0]  phys_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               thit_reg;
    logic               fault_reg;

    logic [PT_W-1:0]    page_in;
    logic [PT_W-1:0]    page_q;
    logic [OFS_W-1:0]   offset;
    logic               accept;
    logic               commit;
    logic               fault;
    logic [FRAME_W-1:0] frame;
    logic [ADDR_W-1:0]  phys;

    logic               ram_we;
    logic [PT_W-1:0]    ram_waddr;
    pte_t               ram_wdata;
    pte_t               ram_rdata;
    tlb_res_t           tres;
    tlb_fill_t          tfill;

    assign page_in = PT_W'(32'(req.logical_address) >> OFS_W);
    assign page_q  = PT_W'(32'(addr_reg) >> OFS_W);
    assign offset  = addr_reg[OFS_W-1:0];
    assign accept  = req.valid && req.ready;
    assign commit  = (state_reg == ST_LOOKUP) && (!ov_reg || rsp.ready);

    assign fault = !tres.hit && !ram_rdata.valid;
    assign frame = tres.hit ? tres.frame :
                   (ram_rdata.valid ? ram_rdata.frame : free_reg[FRAME_W-1:0]);
    assign phys  = ADDR_W'((32'(frame) << OFS_W) | 32'(offset));

    assign acc_next = sat_inc(acc_reg);
    assign flt_next = fault ? sat_inc(flt_reg) : flt_reg;
    assign hit_next = tres.hit ? sat_inc(hit_reg) : hit_reg;

    tlbpt_ram #(
        .WIDTH ($bits(pte_t)),
        .DEPTH (PT_ENTRIES)
    ) u_pt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (page_in),
        .rdata (ram_rdata)
    );

    tlbpt_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_W      (PT_W)
    ) u_tlb (
        .clk   (clk),
        .rst_n (rst_n),
        .page  (page_q),
        .res   (tres),
        .fill  (tfill)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == PT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req.ready       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = page_q;
        ram_wdata.valid = 1'b1;
        ram_wdata.frame = free_reg[FRAME_W-1:0];
        tfill.en        = 1'b0;
        tfill.frame     = frame;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_LOOKUP:
            begin
                ram_we   = commit && fault;
                tfill.en = commit && !tres.hit;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            free_reg  <= '0;
            acc_reg   <= '0;
            flt_reg   <= '0;
            hit_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + PT_W'(1);
            end
            if (commit)
            begin
                acc_reg <= acc_next;
                flt_reg <= flt_next;
                hit_reg <= hit_next;
                if (fault)
                begin
                    free_reg <= free_reg + FREE_W'(1);
                end
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= req.logical_address;
        end
        if (commit)
        begin
            phys_reg  <= phys;
            frame_reg <= frame;
            thit_reg  <= tres.hit;
            fault_reg <= fault;
        end
    end

    assign rsp.valid            = ov_reg;
    assign rsp.physical_address = phys_reg;
    assign rsp.frame_number     = frame_reg;
    assign rsp.tlb_hit          = thit_reg;
    assign rsp.page_fault       = fault_reg;
    assign rsp.access_count     = acc_reg;
    assign rsp.fault_count      = flt_reg;
    assign rsp.hit_count        = hit_reg;

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOKUP)
        else $error("Accepted beat did not move to lookup");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp.valid)
        else $error("Committed beat not presented on the response");

    a_hit_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.tlb_hit && rsp.page_fault))
        else $error("Response flags a TLB hit and a page fault together");

    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.page_fault) |-> rsp.fault_count != '0)
        else $error("Page fault reported with a zero fault count");

endmodule

[verif/tlb_translation_checker.sv]
module tlb_translation_checker import tlbpt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tlbpt_req_if        req,
    tlbpt_rsp_if        rsp,
    output int unsigned errors,
    output int unsigned pending
);

    typedef struct packed {
        logic [ADDR_W-1:0]  physical_address;
        logic [FRAME_W-1:0] frame_number;
        logic               tlb_hit;
        logic               page_fault;
        logic [CNT_W-1:0]   access_count;
        logic [CNT_W-1:0]   fault_count;
        logic [CNT_W-1:0]   hit_count;
    } translation_t;

    bit                 tlb_valid   [TLB_ENTRIES_DEF];
    logic [FRAME_W-1:0] tlb_page    [TLB_ENTRIES_DEF];
    logic [FRAME_W-1:0] tlb_frame   [TLB_ENTRIES_DEF];
    bit                 page_valid  [PT_ENTRIES_DEF];
    logic [FRAME_W-1:0] page_frame  [PT_ENTRIES_DEF];
    int unsigned        fill_slot;
    logic [FREE_W-1:0]  free_frame;
    logic [CNT_W-1:0]   accesses;
    logic [CNT_W-1:0]   faults;
    logic [CNT_W-1:0]   hits;

    translation_t expected_translations[$];

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic translation_t translate_address(input logic [ADDR_W-1:0] addr);
        translation_t t;
        int unsigned  page;
        int unsigned  offset;
        logic [FRAME_W-1:0] frame;
        bit           hit;
        bit           fault;
        page   = (int'(addr) / PAGE_BYTES_DEF) % PT_ENTRIES_DEF;
        offset = int'(addr) % PAGE_BYTES_DEF;
        frame  = '0;
        hit    = 1'b0;
        fault  = 1'b0;
        accesses = bump(accesses);
        for (int i = 0; i < TLB_ENTRIES_DEF; i++)
        begin
            if (!hit && tlb_valid[i] && tlb_page[i] == FRAME_W'(page))
            begin
                frame = tlb_frame[i];
                hit   = 1'b1;
            end
        end
        if (hit)
        begin
            hits = bump(hits);
        end
        else
        begin
            if (page_valid[page])
            begin
                frame = page_frame[page];
            end
            else
            begin
                fault            = 1'b1;
                faults           = bump(faults);
                frame            = free_frame[FRAME_W-1:0];
                page_frame[page] = frame;
                page_valid[page] = 1'b1;
                free_frame       = free_frame + 1'b1;
            end
            if (fill_slot >= TLB_ENTRIES_DEF)
            begin
                fill_slot = 0;
            end
            tlb_page[fill_slot]  = FRAME_W'(page);
            tlb_frame[fill_slot] = frame;
            tlb_valid[fill_slot] = 1'b1;
            fill_slot            = (fill_slot + 1) % TLB_ENTRIES_DEF;
        end
        t.physical_address = ADDR_W'(int'(frame) * PAGE_BYTES_DEF + offset);
        t.frame_number     = frame;
        t.tlb_hit          = hit;
        t.page_fault       = fault;
        t.access_count     = accesses;
        t.fault_count      = faults;
        t.hit_count        = hits;
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        translation_t got;
        translation_t exp;
        if (!rst_n)
        begin
            for (int i = 0; i < TLB_ENTRIES_DEF; i++)
            begin
                tlb_valid[i] = 1'b0;
            end
            for (int i = 0; i < PT_ENTRIES_DEF; i++)
            begin
                page_valid[i] = 1'b0;
            end
            fill_slot  = 0;
            free_frame = '0;
            accesses   = '0;
            faults     = '0;
            hits       = '0;
            expected_translations.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.physical_address = rsp.physical_address;
                got.frame_number     = rsp.frame_number;
                got.tlb_hit          = rsp.tlb_hit;
                got.page_fault       = rsp.page_fault;
                got.access_count     = rsp.access_count;
                got.fault_count      = rsp.fault_count;
                got.hit_count        = rsp.hit_count;
                if (expected_translations.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("ERROR: unexpected response beat pa=%h frame=%h", 
                                 got.physical_address, got.frame_number);
                    end
                end
                else
                begin
                    exp = expected_translations.pop_front();
                    if (got !== exp)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("ERROR: expected pa=%h frame=%h hit=%b fault=%b acc=%0d flt=%0d hits=%0d",
                                     exp.physical_address, exp.frame_number, exp.tlb_hit,
                                     exp.page_fault, exp.access_count, exp.fault_count,
                                     exp.hit_count);
                            $display("       actual   pa=%h frame=%h hit=%b fault=%b acc=%0d flt=%0d hits=%0d",
                                     got.physical_address, got.frame_number, got.tlb_hit,
                                     got.page_fault, got.access_count, got.fault_count,
                                     got.hit_count);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_translations.push_back(translate_address(req.logical_address));
            end
            pending = expected_translations.size();
        end
    end

endmodule

[verif/tb_tlb_page_table_translator.sv]
module tb_tlb_page_table_translator import tlbpt_pkg::*;;

    localparam int unsigned RANDOM_BEATS = 300;
    localparam int unsigned QUIET_BEATS  = 80;
    localparam int unsigned CYCLE_LIMIT  = 150000;

    logic clk;
    logic rst_n;
    bit   quiet;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycle_cnt;

    tlbpt_req_if req_ch ();
    tlbpt_rsp_if rsp_ch ();

    tlb_page_table_translator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tlb_translation_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (mismatches),
        .pending (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycle_cnt = 0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_address(input logic [ADDR_W-1:0] addr);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.logical_address <= addr;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial
    begin
        logic [FRAME_W-1:0] hot_pages  [6];
        logic [FRAME_W-1:0] warm_pages [40];
        logic [FRAME_W-1:0] page;
        int unsigned        pick;
        rst_n                  = 1'b0;
        quiet                  = 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.logical_address <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Cold misses, repeat hits, address extremes, then enough new pages to
        // wrap the replacement pointer so that evicted pages come back from the table.
        send_address(16'h0000);
        send_address(16'h0000);
        send_address(16'hFFFF);
        send_address(16'hFF00);
        send_address(16'h00FF);
        send_address(16'h8001);
        send_address(16'h7FFE);
        send_address(16'h5555);
        send_address(16'hAAAA);
        for (int p = 16; p < 27; p++)
        begin
            send_address({8'(p), 8'($urandom_range(0, 255))});
        end
        send_address(16'h0034);
        send_address(16'hFF80);

        foreach (hot_pages[i])
        begin
            hot_pages[i] = 8'($urandom_range(0, 255));
        end
        foreach (warm_pages[i])
        begin
            warm_pages[i] = 8'($urandom_range(0, 255));
        end

        for (int k = 0; k < RANDOM_BEATS + QUIET_BEATS; k++)
        begin
            if (k == RANDOM_BEATS)
            begin
                quiet = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                page = hot_pages[$urandom_range(0, 5)];
            end
            else if (pick < 80)
            begin
                page = warm_pages[$urandom_range(0, 39)];
            end
            else
            begin
                page = 8'($urandom_range(0, 255));
            end
            send_address({page, 8'($urandom_range(0, 255))});
        end
        req_ch.valid <= 1'b0;

        @(negedge clk);
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tlbpt_pkg.sv
rtl/tlbpt_if.sv
rtl/tlbpt_ram.sv
rtl/tlbpt_tlb.sv
rtl/tlb_page_table_translator.sv
verif/tlb_translation_checker.sv
verif/tb_tlb_page_table_translator.sv
